>>> rtl/core/hlcd_pkg.sv
// Shared package for the head/length/checksum deframer.
// Holds field widths, default constants and the controller/datapath structs.
// No dependencies.
package hlcd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int SUM_W   = 16;

    // Defaults
    localparam int             BUF_LEN_DEF   = 64;
    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hAA;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_head;   // store the head byte at entry 0, restart the frame
        logic wr_len;    // store the length byte, latch the length
        logic wr_data;   // store a body byte at the write position
        logic rd_start;  // read entry 0 for replay
        logic rd_next;   // read the next entry for replay
    } hlcd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_head;   // received byte equals the head byte
        logic len_ok;    // received byte is a usable length
        logic last_pos;  // write position is the final checksum byte
        logic sum_ok;    // running sum equals the checksum word
        logic last_out;  // replay index is the final byte
    } hlcd_stat_t;

endpackage

>>> rtl/core/hlcd_if.sv
// Valid/ready stream interfaces for the deframer: received bytes in,
// verified frame bytes out. Depends on hlcd_pkg.
interface hlcd_rx_if;
    import hlcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlcd_frame_if;
    import hlcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  frame_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last_byte;

    modport source (output valid, output frame_byte, output byte_index, output last_byte,
                    input ready);
    modport sink   (input valid, input frame_byte, input byte_index, input last_byte,
                    output ready);
endinterface

>>> rtl/core/hlcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module hlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/hlcd_ctrl.sv
// Frame controller: hunts for the head, takes the length and body,
// then replays a verified frame. Depends on hlcd_pkg.
module hlcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  hlcd_pkg::hlcd_stat_t stat,
    output hlcd_pkg::hlcd_cmd_t  cmd
);
    import hlcd_pkg::*;

    typedef enum logic [1:0] {
        S_HEAD,
        S_LEN,
        S_DATA,
        S_SHOW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rx_acc;
    logic   out_acc;

    assign rx_ready  = (state_reg != S_SHOW);
    assign out_valid = (state_reg == S_SHOW);
    assign rx_acc    = rx_valid && rx_ready;
    assign out_acc   = out_valid && out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_HEAD:
            begin
                if (rx_acc && stat.is_head)
                begin
                    cmd.wr_head = 1'b1;
                    state_next  = S_LEN;
                end
            end
            S_LEN:
            begin
                if (rx_acc)
                begin
                    if (stat.len_ok)
                    begin
                        cmd.wr_len = 1'b1;
                        state_next = S_DATA;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_DATA:
            begin
                if (rx_acc)
                begin
                    cmd.wr_data = 1'b1;
                    if (stat.last_pos)
                    begin
                        if (stat.sum_ok)
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_SHOW;
                        end
                        else
                        begin
                            state_next = S_HEAD;
                        end
                    end
                end
            end
            S_SHOW:
            begin
                if (out_acc)
                begin
                    if (stat.last_out)
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_HEAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HEAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/hlcd_dp.sv
// Deframer datapath: head register, frame store, positions, running sum
// and replay index. Depends on hlcd_pkg and hlcd_ram.
module hlcd_dp #(
    parameter int BUF_LEN = hlcd_pkg::BUF_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hlcd_pkg::BYTE_W-1:0]   cfg_wdata,
    input  logic [hlcd_pkg::BYTE_W-1:0]   rx_byte,
    input  hlcd_pkg::hlcd_cmd_t           cmd,
    output hlcd_pkg::hlcd_stat_t          stat,
    output logic [hlcd_pkg::BYTE_W-1:0]   frame_byte,
    output logic [hlcd_pkg::INDEX_W-1:0]  byte_index,
    output logic                          last_byte
);
    import hlcd_pkg::*;

    localparam int AW = $clog2(BUF_LEN);
    localparam logic [BYTE_W:0] LEN_MAX = (BYTE_W+1)'(BUF_LEN - 2);
    localparam logic [AW-1:0]   POS_ONE = AW'(1);
    localparam logic [AW-1:0]   POS_TWO = AW'(2);

    logic [BYTE_W-1:0] head_byte_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     len_reg;
    logic [AW-1:0]     idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [BYTE_W-1:0] hi_reg;

    logic [AW-1:0]     len_cur;
    logic [AW-1:0]     len_end;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic              body_wr;

    // Length in force for this byte (new one while it is being taken)
    assign len_cur = cmd.wr_len ? AW'(rx_byte) : len_reg;
    assign len_end = len_reg + POS_ONE;
    assign body_wr = cmd.wr_len || cmd.wr_data;

    // Status
    assign stat.is_head  = (rx_byte == head_byte_reg);
    assign stat.len_ok   = (rx_byte != '0) && ({1'b0, rx_byte} <= LEN_MAX);
    assign stat.last_pos = (pos_reg == len_end);
    assign stat.sum_ok   = (sum_reg == {hi_reg, rx_byte});
    assign stat.last_out = (idx_reg == len_end);

    // Frame store ports
    assign ram_we    = cmd.wr_head || body_wr;
    assign ram_waddr = cmd.wr_head ? '0 : pos_reg;
    assign ram_re    = cmd.rd_start || cmd.rd_next;
    assign ram_raddr = cmd.rd_start ? '0 : idx_reg + POS_ONE;

    hlcd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (frame_byte)
    );

    // Replay outputs
    assign byte_index = INDEX_W'(idx_reg);
    assign last_byte  = stat.last_out;

    // Head byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_byte_reg <= HEAD_RESET;
        end
        else if (cfg_we)
        begin
            head_byte_reg <= cfg_wdata;
        end
    end

    // Write position, length and replay index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.wr_head)
            begin
                pos_reg <= POS_ONE;
            end
            else if (cmd.wr_len)
            begin
                pos_reg <= POS_TWO;
                len_reg <= len_cur;
            end
            else if (cmd.wr_data)
            begin
                pos_reg <= pos_reg + POS_ONE;
            end

            if (cmd.rd_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                idx_reg <= idx_reg + POS_ONE;
            end
        end
    end

    // Running sum over positions 1..L-1; checksum high byte at position L
    always_ff @(posedge clk)
    begin
        if (cmd.wr_head)
        begin
            sum_reg <= '0;
        end
        else if (body_wr && (pos_reg < len_cur))
        begin
            sum_reg <= sum_reg + SUM_W'(rx_byte);
        end

        if (body_wr && (pos_reg == len_cur))
        begin
            hi_reg <= rx_byte;
        end
    end

endmodule

>>> rtl/core/head_length_checksum_deframer.sv
// Head/length/sum16 deframer top level. Depends on hlcd_pkg, hlcd_if,
// hlcd_ram, hlcd_ctrl and hlcd_dp.
//
// Received bytes are taken one per cycle while a frame is being collected:
// the block waits for the head byte (cfg_wdata, reset 0xAA), takes a length
// L in 1..BUF_LEN-2, then L more bytes. If the 16-bit wrapping sum of frame
// bytes 1..L-1 equals the big-endian word in the last two bytes, the whole
// frame of L+2 bytes is replayed on the frame channel, head first, one byte
// per cycle while the sink is ready, last_byte marking the final one. The
// input is held off during replay, which comes from the one frame store.
// Bad frames and bad lengths are dropped silently; the store needs no
// clearing pass after reset.
module head_length_checksum_deframer #(
    parameter int BUF_LEN = hlcd_pkg::BUF_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hlcd_pkg::BYTE_W-1:0]  cfg_wdata,
    hlcd_rx_if.sink                      rx,
    hlcd_frame_if.source                 frame
);
    import hlcd_pkg::*;

    hlcd_cmd_t  cmd;
    hlcd_stat_t stat;

    // Controller
    hlcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx.valid),
        .rx_ready  (rx.ready),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    hlcd_dp #(
        .BUF_LEN (BUF_LEN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .rx_byte    (rx.rx_byte),
        .cmd        (cmd),
        .stat       (stat),
        .frame_byte (frame.frame_byte),
        .byte_index (frame.byte_index),
        .last_byte  (frame.last_byte)
    );

    // Input is never taken while a frame is being replayed
    assert property (@(posedge clk) disable iff (!rst_n)
        !(frame.valid && rx.ready))
        else $error("input ready during replay");

    // Replay opens at the head byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame.valid) |-> (frame.byte_index == '0))
        else $error("replay does not start at index zero");

    // Within a frame the index steps by one per transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready && !frame.last_byte) |=>
            (frame.valid && (frame.byte_index == INDEX_W'($past(frame.byte_index) + 1'b1))))
        else $error("replay index did not advance by one");

    // Replay ends after the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready && frame.last_byte) |=> !frame.valid)
        else $error("replay continued past the last byte");

endmodule
